[design/hsvrgb_pkg.sv]
// Shared widths and hue sector codes for the HSV to RGB converter.
// No dependencies.
`default_nettype none
package hsvrgb_pkg;

   localparam int unsigned ChanWidth   = 8;
   localparam int unsigned SectorWidth = 3;
   localparam int unsigned MulWidth    = 16;   // S*F, S*(256-F)
   localparam int unsigned CompWidth   = 17;   // 65536 - S*F
   localparam int unsigned QtWidth     = 25;   // V * (65536 - S*F)
   localparam int unsigned PWidth      = 17;   // V * (256 - S)

   typedef logic [ChanWidth-1:0]   chan_type;
   typedef logic [SectorWidth-1:0] sector_type;

   localparam sector_type SECTOR_RED_YELLOW    = 3'd0;
   localparam sector_type SECTOR_YELLOW_GREEN  = 3'd1;
   localparam sector_type SECTOR_GREEN_CYAN    = 3'd2;
   localparam sector_type SECTOR_CYAN_BLUE     = 3'd3;
   localparam sector_type SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SECTOR_MAGENTA_RED   = 3'd5;

endpackage
`default_nettype wire

[design/hsv_to_rgb_converter_top.sv]
// HSV to RGB converter, four stage pipeline, one module.
// Depends on hsvrgb_pkg for widths and sector codes.
//
// A req_ beat accepted at an edge is loaded into the stage 1, 2, 3 and 4
// registers in turn; rsp_valid is the stage 4 valid bit.
// Throughput: one beat per clock unless rsp_ready stalls; the multiply stages
// (S*F, then V*(1-S*F)) set the pipeline depth, each stage carries a valid bit.
// Reset: synchronous, active high, clears the stage valid bits only; the
// datapath registers hold whatever they last loaded.
`default_nettype none
module hsv_to_rgb_converter_top
   import hsvrgb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_hue,
   input  wire logic [7:0] req_saturation,
   input  wire logic [7:0] req_brightness,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue
);

   // ---------------------------------------------------------------
   // Stall control: a stage loads when it is empty or the stage after
   // it loads. The chain is short, so ready ripples back combinationally
   // and bubbles get squeezed out while the output is held.
   // ---------------------------------------------------------------
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic en1, en2, en3, en4;

   assign en4       = !vld4_ff || rsp_ready;
   assign en3       = !vld3_ff || en4;
   assign en2       = !vld2_ff || en3;
   assign en1       = !vld1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = vld4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (en1) vld1_ff <= req_valid;
         if (en2) vld2_ff <= vld1_ff;
         if (en3) vld3_ff <= vld2_ff;
         if (en4) vld4_ff <= vld3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: scaled hue = 6*H = 4H + 2H, split into sector and fraction.
   // ---------------------------------------------------------------
   logic [10:0] scaled_in;
   sector_type  sector1_ff, sector2_ff, sector3_ff;
   chan_type    frac1_ff;
   chan_type    sat1_ff, sat2_ff;
   chan_type    val1_ff, val2_ff, val3_ff;

   assign scaled_in = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         sector1_ff <= scaled_in[10:8];
         frac1_ff   <= scaled_in[7:0];
         sat1_ff    <= req_saturation;
         val1_ff    <= req_brightness;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: saturation products S*F and S*(256-F).
   // 256-F never exceeds 256; S*256 is 16 bits at most.
   // ---------------------------------------------------------------
   logic [8:0]          inv_frac;
   logic [MulWidth-1:0] sf_in, sg_in;
   logic [MulWidth-1:0] sf2_ff, sg2_ff;

   assign inv_frac = 9'd256 - {1'b0, frac1_ff};
   assign sf_in    = MulWidth'({8'd0, sat1_ff} * {8'd0, frac1_ff});
   assign sg_in    = MulWidth'({8'd0, sat1_ff} * {7'd0, inv_frac});

   always_ff @(posedge clock) begin
      if (en2 && vld1_ff) begin
         sector2_ff <= sector1_ff;
         sat2_ff    <= sat1_ff;
         val2_ff    <= val1_ff;
         sf2_ff     <= sf_in;
         sg2_ff     <= sg_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: brightness times the complemented terms.
   // With S=0 every level below collapses to floor(255V/256), so grey
   // needs no separate path.
   // ---------------------------------------------------------------
   logic [CompWidth-1:0] cq, ct;
   logic [8:0]           inv_sat;
   logic [QtWidth-1:0]   nq_in, nt_in, nq3_ff, nt3_ff;
   logic [PWidth-1:0]    np_in, np3_ff;

   assign cq      = 17'h10000 - {1'b0, sf2_ff};
   assign ct      = 17'h10000 - {1'b0, sg2_ff};
   assign inv_sat = 9'd256 - {1'b0, sat2_ff};
   assign nq_in   = QtWidth'({17'd0, val2_ff} * {8'd0, cq});
   assign nt_in   = QtWidth'({17'd0, val2_ff} * {8'd0, ct});
   assign np_in   = PWidth'({9'd0, val2_ff} * {8'd0, inv_sat});

   always_ff @(posedge clock) begin
      if (en3 && vld2_ff) begin
         sector3_ff <= sector2_ff;
         val3_ff    <= val2_ff;
         nq3_ff     <= nq_in;
         nt3_ff     <= nt_in;
         np3_ff     <= np_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: times 255 as (x<<8)-x, floor by part-select, then route
   // levels to channels by sector.
   // ---------------------------------------------------------------
   logic [33:0] sq, st;
   logic [25:0] sp;
   logic [16:0] sv;
   chan_type    lq, lt, lp, lv;
   chan_type    red_in, green_in, blue_in;
   chan_type    red_ff, green_ff, blue_ff;

   assign sq = {1'b0, nq3_ff, 8'd0} - {9'd0, nq3_ff};
   assign st = {1'b0, nt3_ff, 8'd0} - {9'd0, nt3_ff};
   assign sp = {1'b0, np3_ff, 8'd0} - {9'd0, np3_ff};
   assign sv = {1'b0, val3_ff, 8'd0} - {9'd0, val3_ff};
   assign lq = sq[31:24];
   assign lt = st[31:24];
   assign lp = sp[23:16];
   assign lv = sv[15:8];

   always_comb begin
      unique case (sector3_ff)
         SECTOR_RED_YELLOW: begin
            red_in = lv; green_in = lt; blue_in = lp;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = lq; green_in = lv; blue_in = lp;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = lp; green_in = lv; blue_in = lt;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = lp; green_in = lq; blue_in = lv;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = lt; green_in = lp; blue_in = lv;
         end
         default: begin
            red_in = lv; green_in = lp; blue_in = lq;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4 && vld3_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // 8-bit hue never reaches sector 6 or 7.
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      vld1_ff |-> (sector1_ff <= SECTOR_MAGENTA_RED))
      else $error("hue sector out of range");

   // Levels are floor(255*x) with x < 1, so full scale never appears.
   a_no_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red != 8'hFF && rsp_green != 8'hFF && rsp_blue != 8'hFF))
      else $error("channel at full scale");

   // A stalled middle stage keeps its beat.
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      vld3_ff && !en4 |=> vld3_ff && $stable(nq3_ff) && $stable(sector3_ff))
      else $error("stage 3 lost data under stall");

   // An empty first stage always takes a new beat.
   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !vld1_ff |-> req_ready)
      else $error("input stalled with empty first stage");

   // An accepted beat moves into stage 1.
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld1_ff)
      else $error("accepted beat not captured");

endmodule
`default_nettype wire

[bench/hsv_to_rgb_converter_top_tb.sv]
// Self-checking bench for hsv_to_rgb_converter_top: directed corners, then random HSV
// beats, with random idling on both channels, checked against an in-bench predictor.
// Depends on hsvrgb_pkg (chan_type, sector codes) and the converter RTL.
`default_nettype none
module hsv_to_rgb_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsvrgb_pkg::*;

   // One predicted output pixel, tagged with the HSV beat that produced it.
   typedef struct packed {
      chan_type hue;
      chan_type sat;
      chan_type bri;
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_pixel_type;

   localparam int unsigned IdlePercent = 19;
   localparam int unsigned MaxPrinted  = 40;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_ready;
   chan_type req_hue        = '0;
   chan_type req_saturation = '0;
   chan_type req_brightness = '0;
   logic     rsp_valid;
   logic     rsp_ready      = 1'b0;
   chan_type rsp_red;
   chan_type rsp_green;
   chan_type rsp_blue;

   // Expected pixels, oldest first; filled on req_ accept, drained on rsp_ accept.
   rgb_pixel_type pending_rgb[$];
   int unsigned   error_count   = 0;
   int unsigned   beats_sent    = 0;
   int unsigned   pixels_seen   = 0;
   int unsigned   directed_sent = 0;
   // When set, neither side idles: back-to-back beats, full throughput.
   bit            steady_flow   = 1'b0;

   hsv_to_rgb_converter_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // floor(255 * num / 2^shift), num held exactly in 64 bits.
   function automatic chan_type floor255(input longint unsigned num,
                                         input int unsigned shift);
      longint unsigned prod;
      prod = (num * 64'd255) >> shift;
      return prod[7:0];
   endfunction

   // Exact fixed-point HSV to RGB. Levels:
   //   v = V/256, p = V(256-S)/2^16,
   //   q = V(65536-S*F)/2^24, t = V(65536-S(256-F))/2^24
   // each channel = floor(255 * level). Sector = (6H)>>8, F = low byte of 6H.
   function automatic rgb_pixel_type hsv_to_rgb_expected(input chan_type hue,
                                                         input chan_type sat,
                                                         input chan_type bri);
      rgb_pixel_type   px;
      longint unsigned h, s, v, scaled, frac;
      sector_type      sector;
      chan_type        lv, lp, lq, lt;
      h      = hue;
      s      = sat;
      v      = bri;
      px.hue = hue;
      px.sat = sat;
      px.bri = bri;
      lv     = floor255(v, 8);
      if (s == 0) begin
         // grey: all channels carry the value level
         px.red   = lv;
         px.green = lv;
         px.blue  = lv;
      end else begin
         scaled = h * 6;
         sector = sector_type'(scaled >> 8);
         frac   = scaled & 64'hFF;
         lp     = floor255(v * (256 - s), 16);
         lq     = floor255(v * (65536 - s * frac), 24);
         lt     = floor255(v * (65536 - s * (256 - frac)), 24);
         case (sector)
            SECTOR_RED_YELLOW: begin
               px.red = lv; px.green = lt; px.blue = lp;
            end
            SECTOR_YELLOW_GREEN: begin
               px.red = lq; px.green = lv; px.blue = lp;
            end
            SECTOR_GREEN_CYAN: begin
               px.red = lp; px.green = lv; px.blue = lt;
            end
            SECTOR_CYAN_BLUE: begin
               px.red = lp; px.green = lq; px.blue = lv;
            end
            SECTOR_BLUE_MAGENTA: begin
               px.red = lt; px.green = lp; px.blue = lv;
            end
            default: begin
               // magenta to red; 8-bit hue never reaches sector 6 or 7
               px.red = lv; px.green = lp; px.blue = lq;
            end
         endcase
      end
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MaxPrinted)
         $display("%0t ns  MISMATCH  %s", $time, what);
   endtask

   // Prediction is pushed before the pop in the same edge, so ordering
   // between the two channels never depends on scheduling.
   always @(posedge clock) begin : rgb_check
      rgb_pixel_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_rgb.push_back(hsv_to_rgb_expected(req_hue, req_saturation,
                                                      req_brightness));
            beats_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            pixels_seen++;
            if (pending_rgb.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp_ beat rgb=(%0d,%0d,%0d)",
                                         rsp_red, rsp_green, rsp_blue));
            end else begin
               want = pending_rgb.pop_front();
               if (rsp_red !== want.red)
                  report_mismatch($sformatf("red   hsv=(%0d,%0d,%0d) got %0d want %0d",
                                            want.hue, want.sat, want.bri,
                                            rsp_red, want.red));
               if (rsp_green !== want.green)
                  report_mismatch($sformatf("green hsv=(%0d,%0d,%0d) got %0d want %0d",
                                            want.hue, want.sat, want.bri,
                                            rsp_green, want.green));
               if (rsp_blue !== want.blue)
                  report_mismatch($sformatf("blue  hsv=(%0d,%0d,%0d) got %0d want %0d",
                                            want.hue, want.sat, want.bri,
                                            rsp_blue, want.blue));
            end
         end
      end
   end

   // Result side back-pressure: stall about IdlePercent of cycles unless the
   // steady stretch is running.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (steady_flow)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= IdlePercent);
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Called at a rising edge; returns at the edge where the beat was taken.
   // Valid stays high between consecutive beats; an idle gap of random length now
   // and then (~12% of beats) gives roughly 19% sender idle time.
   task automatic send_hsv(input chan_type hue, input chan_type sat,
                           input chan_type bri);
      int unsigned gap;
      gap = 0;
      if (!steady_flow && $urandom_range(99) < 12)
         gap = $urandom_range(3, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      do @(posedge clock); while (!req_ready);
   endtask

   // Biased toward the ends and the middle of the 8-bit range.
   function automatic chan_type pick_edge_value();
      case ($urandom_range(5))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd254;
         3:       return 8'd255;
         4:       return 8'd128;
         default: return chan_type'($urandom_range(255));
      endcase
   endfunction

   // Extremes, grey, and both sides of every sector boundary.
   task automatic test_directed_corners();
      // all-zero, all-max
      send_hsv(8'd0, 8'd0, 8'd0);
      send_hsv(8'd255, 8'd255, 8'd255);
      // zero saturation: grey at several brightness levels
      send_hsv(8'd0, 8'd0, 8'd255);
      send_hsv(8'd100, 8'd0, 8'd1);
      send_hsv(8'd200, 8'd0, 8'd128);
      send_hsv(8'd255, 8'd0, 8'd255);
      // sector edges: 0 first, 42|43, 85|86, 127|128, 170|171, 213|214
      send_hsv(8'd0, 8'd255, 8'd255);
      send_hsv(8'd42, 8'd255, 8'd255);
      send_hsv(8'd43, 8'd255, 8'd255);
      send_hsv(8'd85, 8'd255, 8'd255);
      send_hsv(8'd86, 8'd255, 8'd255);
      send_hsv(8'd127, 8'd255, 8'd255);
      send_hsv(8'd128, 8'd255, 8'd255);
      send_hsv(8'd170, 8'd255, 8'd255);
      send_hsv(8'd171, 8'd255, 8'd255);
      send_hsv(8'd213, 8'd255, 8'd255);
      send_hsv(8'd214, 8'd255, 8'd255);
      // minimum nonzero saturation, zero brightness with full saturation, one mid-range point
      send_hsv(8'd128, 8'd1, 8'd1);
      send_hsv(8'd170, 8'd255, 8'd0);
      send_hsv(8'd21, 8'd1, 8'd255);
      send_hsv(8'd234, 8'd128, 8'd200);
      directed_sent = 21;
   endtask

   task automatic test_random_full(input int unsigned count);
      repeat (count)
         send_hsv(chan_type'($urandom_range(255)), chan_type'($urandom_range(255)),
                  chan_type'($urandom_range(255)));
   endtask

   task automatic test_random_extremes(input int unsigned count);
      repeat (count)
         send_hsv(chan_type'($urandom_range(255)), pick_edge_value(),
                  pick_edge_value());
   endtask

   // Long stretch with no idling on either side.
   task automatic test_back_to_back(input int unsigned count);
      steady_flow = 1'b1;
      test_random_full(count);
      steady_flow = 1'b0;
   endtask

   // Drop valid, wait for every expected pixel, then let the pipe settle so a
   // stray extra beat would still be caught.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_full(450);
      test_random_extremes(450);
      test_back_to_back(230);
      drain_pipeline();

      $display("Sent %0d HSV beats (%0d directed, rest random incl. a no-stall run),",
               beats_sent, directed_sent);
      $display("checked %0d RGB beats, %0d field mismatches.", pixels_seen, error_count);
      if (error_count == 0)
         $display("** hsv_to_rgb_converter_top: PASSED **");
      else
         $display("** hsv_to_rgb_converter_top: FAILED **");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (~1150 beats with gaps and stalls).
   initial begin
      #2_000_000;
      $display("Timeout with %0d pixels still expected.", pending_rgb.size());
      $display("** hsv_to_rgb_converter_top: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

[hsv_to_rgb_converter_top.f]
design/hsvrgb_pkg.sv
design/hsv_to_rgb_converter_top.sv
bench/hsv_to_rgb_converter_top_tb.sv
